// ===== hdl/wpa_pkg.sv =====
// Package for the worker pool allocator: payload structs, command and status
// codes, datapath operation codes and small helper functions.
// Depends on nothing; every other file of the block imports it.
package wpa_pkg;

  localparam int unsigned NumWorkers = 16;

  localparam logic [2:0] CMD_REQUEST  = 3'd0;
  localparam logic [2:0] CMD_DONE     = 3'd1;
  localparam logic [2:0] CMD_TICK     = 3'd2;
  localparam logic [2:0] CMD_COLLECT  = 3'd3;
  localparam logic [2:0] CMD_STOP_ALL = 3'd4;
  localparam logic [2:0] CMD_POPULATE = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_AVAIL = 2'd1;
  localparam logic [1:0] ST_IGNORED  = 2'd2;

  localparam logic [1:0] REG_MIN   = 2'd0;
  localparam logic [1:0] REG_MAX   = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  localparam logic [1:0] CLS_BUSY    = 2'd0;
  localparam logic [1:0] CLS_FRESH   = 2'd1;
  localparam logic [1:0] CLS_EXPIRED = 2'd2;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] worker_id;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] granted_id;
    logic [4:0] allocated_count;
    logic [4:0] busy_count;
    logic [4:0] free_count;
    logic [4:0] released_count;
  } res_t;

  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_DECODE  = 4'd1,
    OP_HK_CHK  = 4'd2,
    OP_SORT    = 4'd3,
    OP_FLIP    = 4'd4,
    OP_RELEASE = 4'd5,
    OP_SCAN    = 4'd6,
    OP_POP     = 4'd7,
    OP_RESULT  = 4'd8
  } op_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic       age_hit;
    logic       hk_skip;
    logic       sort_last;
    logic       rel_done;
    logic       scan_done;
    logic       pop_done;
  } dp_status_t;

  // Lowest worker id whose bit is clear.
  function automatic logic [3:0] lowest_free(input logic [15:0] used);
    logic [3:0] id;
    id = '0;
    for (int i = NumWorkers - 1; i >= 0; i--) begin
      if (!used[i]) begin
        id = 4'(i);
      end
    end
    return id;
  endfunction

  function automatic logic [4:0] popcount16(input logic [15:0] v);
    logic [4:0] c;
    c = '0;
    for (int i = 0; i < NumWorkers; i++) begin
      c = c + 5'(v[i]);
    end
    return c;
  endfunction

endpackage

// ===== hdl/wpa_ctrl.sv =====
// Controller of the worker pool allocator: one-hot sequencer that steps the
// datapath through decode, housekeeping, scan and populate.
// Depends on wpa_pkg.
module wpa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output logic                done_o,
  input  wpa_pkg::dp_status_t st_i,
  output wpa_pkg::op_e        op_o
);
  import wpa_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_HK_CHK = 9'b000000100,
    S_SORT   = 9'b000001000,
    S_FLIP   = 9'b000010000,
    S_REL    = 9'b000100000,
    S_SCAN   = 9'b001000000,
    S_POP    = 9'b010000000,
    S_RESULT = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   done_q;
  logic   is_req;

  assign is_req = (st_i.cmd == CMD_REQUEST);

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_DECODE;
      end
      S_DECODE: begin
        op_o = OP_DECODE;
        if (is_req) begin
          state_d = st_i.age_hit ? S_HK_CHK : S_SCAN;
        end else if (st_i.cmd == CMD_COLLECT) begin
          state_d = S_HK_CHK;
        end else if (st_i.cmd == CMD_POPULATE) begin
          state_d = S_POP;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_HK_CHK: begin
        op_o = OP_HK_CHK;
        if (!st_i.hk_skip) state_d = S_SORT;
        else state_d = is_req ? S_SCAN : S_RESULT;
      end
      S_SORT: begin
        op_o = OP_SORT;
        if (st_i.sort_last) state_d = S_FLIP;
      end
      S_FLIP: begin
        op_o    = OP_FLIP;
        state_d = S_REL;
      end
      S_REL: begin
        op_o = OP_RELEASE;
        if (st_i.rel_done) state_d = is_req ? S_SCAN : S_RESULT;
      end
      S_SCAN: begin
        op_o = OP_SCAN;
        if (st_i.scan_done) state_d = S_RESULT;
      end
      S_POP: begin
        op_o = OP_POP;
        if (st_i.pop_done) state_d = S_RESULT;
      end
      S_RESULT: begin
        op_o    = OP_RESULT;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_RESULT);
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ===== hdl/wpa_dpath.sv =====
// Datapath of the worker pool allocator: list buffers, worker flags, idle
// timestamps, limit registers, counters and the result register.
// Depends on wpa_pkg; sequenced by wpa_ctrl.
module wpa_dpath #(
  parameter int unsigned HOUSEKEEP_PERIOD = 32,
  parameter int unsigned TIME_BITS        = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                busy,
  input  wpa_pkg::req_t       req_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  wpa_pkg::op_e        op_i,
  output wpa_pkg::dp_status_t st_o,
  output wpa_pkg::res_t       res_o
);
  import wpa_pkg::*;

  localparam int unsigned AgeW = $clog2(HOUSEKEEP_PERIOD + 1);
  localparam int unsigned CmpW = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [2:0]           cmd_q;
  logic [3:0]           wid_q;
  logic [4:0]           len_q, idx_q, n_q, keep_q, rel_q;
  logic [1:0]           pass_q;
  logic                 sel_q;
  logic [1:0]           stat_q;
  logic [3:0]           grant_q;
  logic [15:0]          inl_q, busy_q, fin_q;
  logic [TIME_BITS-1:0] now_q;
  logic [AgeW-1:0]      age_q;
  logic [4:0]           min_q, max_q;
  logic [31:0]          lim_q;
  res_t                 res_q;

  // Two list banks, selected by sel_q; sorting writes the other bank.
  logic [3:0]           list_mem [32];
  logic [TIME_BITS-1:0] since_mem [NumWorkers];

  logic [4:0]           eff_min, eff_max;
  logic [3:0]           rd_addr, cur_id, low_id;
  logic [1:0]           cls;
  logic [TIME_BITS-1:0] idle_time;
  logic                 free_ok, idx_in;
  logic                 wr_en;
  logic [4:0]           wr_addr;
  logic [3:0]           wr_data;
  logic [4:0]           bcnt;

  assign eff_min = (min_q > 5'(NumWorkers)) ? 5'(NumWorkers) : min_q;
  assign eff_max = (max_q > 5'(NumWorkers)) ? 5'(NumWorkers) : max_q;

  assign rd_addr   = (op_i == OP_RELEASE) ? 4'(len_q - 5'd1) : idx_q[3:0];
  assign cur_id    = list_mem[{sel_q, rd_addr}];
  assign low_id    = lowest_free(inl_q);
  assign free_ok   = ~&inl_q;
  assign idx_in    = (idx_q < len_q);
  assign idle_time = now_q - since_mem[cur_id];
  assign bcnt      = popcount16(busy_q);

  always_comb begin
    if (busy_q[cur_id]) cls = CLS_BUSY;
    else if (!fin_q[cur_id]) cls = CLS_EXPIRED;
    else if (CmpW'(idle_time) < CmpW'(lim_q)) cls = CLS_FRESH;
    else cls = CLS_EXPIRED;
  end

  always_comb begin
    st_o.cmd       = cmd_q;
    st_o.age_hit   = ((AgeW + 1)'(age_q) + 1'b1) >= (AgeW + 1)'(HOUSEKEEP_PERIOD);
    st_o.hk_skip   = (len_q <= eff_min);
    st_o.sort_last = (pass_q == 2'd2) && (idx_q == len_q - 5'd1);
    st_o.rel_done  = (len_q <= keep_q);
    st_o.scan_done = !idx_in || !busy_q[cur_id];
    st_o.pop_done  = !((len_q < eff_min) && free_ok);
  end

  // List write port: sorted copy into the other bank, or an append.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {sel_q, len_q[3:0]};
    wr_data = low_id;
    case (op_i)
      OP_SORT: begin
        wr_en   = (cls == pass_q);
        wr_addr = {~sel_q, n_q[3:0]};
        wr_data = cur_id;
      end
      OP_SCAN: begin
        wr_en = !idx_in && (len_q < eff_max) && free_ok;
      end
      OP_POP: begin
        wr_en = (len_q < eff_min) && free_ok;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) list_mem[wr_addr] <= wr_data;
    if (op_i == OP_DECODE && cmd_q == CMD_DONE && inl_q[wid_q] && busy_q[wid_q]) begin
      since_mem[wid_q] <= now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= '0;
      wid_q   <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      n_q     <= '0;
      keep_q  <= '0;
      rel_q   <= '0;
      pass_q  <= '0;
      sel_q   <= 1'b0;
      stat_q  <= ST_OK;
      grant_q <= '0;
      inl_q   <= '0;
      busy_q  <= '0;
      fin_q   <= '0;
      now_q   <= '0;
      age_q   <= '0;
      min_q   <= 5'd1;
      max_q   <= 5'd16;
      lim_q   <= 32'd60;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MIN:   min_q <= cfg_wdata_i[4:0];
          REG_MAX:   max_q <= cfg_wdata_i[4:0];
          REG_LIMIT: lim_q <= cfg_wdata_i;
          default:   ;
        endcase
      end
      if (start && !busy) begin
        cmd_q <= req_i.cmd;
        wid_q <= req_i.worker_id;
      end
      case (op_i)
        OP_DECODE: begin
          idx_q   <= '0;
          n_q     <= '0;
          keep_q  <= '0;
          pass_q  <= '0;
          // Stop-all reports the whole list as released.
          rel_q   <= (cmd_q == CMD_STOP_ALL) ? len_q : 5'd0;
          // A done for a worker that is not busy is ignored.
          stat_q  <= (cmd_q == CMD_DONE && !(inl_q[wid_q] && busy_q[wid_q])) ?
                     ST_IGNORED : ST_OK;
          grant_q <= '0;
          case (cmd_q)
            CMD_REQUEST: age_q <= age_q + 1'b1;
            CMD_DONE: begin
              if (inl_q[wid_q] && busy_q[wid_q]) begin
                busy_q[wid_q] <= 1'b0;
                fin_q[wid_q]  <= 1'b1;
              end
            end
            CMD_TICK: now_q <= now_q + 1'b1;
            CMD_STOP_ALL: begin
              len_q  <= '0;
              inl_q  <= '0;
              busy_q <= '0;
              fin_q  <= '0;
            end
            default: ;
          endcase
        end
        OP_HK_CHK: age_q <= '0;
        OP_SORT: begin
          if (cls == pass_q) begin
            n_q <= n_q + 1'b1;
            if (pass_q != CLS_EXPIRED) keep_q <= keep_q + 1'b1;
          end
          if (idx_q == len_q - 5'd1) begin
            idx_q  <= '0;
            pass_q <= pass_q + 1'b1;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        OP_FLIP: begin
          sel_q <= ~sel_q;
          if (keep_q < eff_min) keep_q <= eff_min;
        end
        OP_RELEASE: begin
          if (len_q > keep_q) begin
            len_q          <= len_q - 1'b1;
            inl_q[cur_id]  <= 1'b0;
            busy_q[cur_id] <= 1'b0;
            fin_q[cur_id]  <= 1'b0;
            rel_q          <= rel_q + 1'b1;
          end
        end
        OP_SCAN: begin
          if (idx_in) begin
            if (!busy_q[cur_id]) begin
              busy_q[cur_id] <= 1'b1;
              grant_q        <= cur_id;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end else if (wr_en) begin
            inl_q[low_id]  <= 1'b1;
            busy_q[low_id] <= 1'b1;
            fin_q[low_id]  <= 1'b0;
            grant_q        <= low_id;
            len_q          <= len_q + 1'b1;
          end else begin
            stat_q <= ST_NO_AVAIL;
          end
        end
        OP_POP: begin
          if (wr_en) begin
            inl_q[low_id]  <= 1'b1;
            busy_q[low_id] <= 1'b0;
            fin_q[low_id]  <= 1'b0;
            len_q          <= len_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_RESULT) begin
      res_q.status          <= stat_q;
      res_q.granted_id      <= grant_q;
      res_q.allocated_count <= len_q;
      res_q.busy_count      <= bcnt;
      res_q.free_count      <= (eff_max > bcnt) ? (eff_max - bcnt) : 5'd0;
      res_q.released_count  <= rel_q;
    end
  end

  assign res_o = res_q;

  // Busy or finished marks only ever sit on workers that are in the list.
  a_busy_listed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q & ~inl_q) == 16'd0) else $error("busy mark on unlisted worker");
  a_fin_listed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_q & ~inl_q) == 16'd0) else $error("finished mark on unlisted worker");
  a_len_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i != OP_SORT |-> popcount16(inl_q) == len_q)
    else $error("list length disagrees with listed workers");

endmodule

// ===== hdl/worker_pool_allocator_core.sv =====
// Top level of the worker pool allocator: controller plus datapath.
// Depends on wpa_pkg, wpa_ctrl and wpa_dpath.
//
//   Channel    Signals                               Direction
//   request    start, busy, req_i                    in, accepted when start & !busy
//   result     done_o, res_o                         out, one-cycle strobe
//   config     cfg_we_i, cfg_idx_i, cfg_wdata_i      in, written on each enable
//
// A request passes through decode and result plus its work: a done, tick
// or stop-all has no further work, a populate appends idle workers up to the
// minimum. A request for a worker scans the list one entry a cycle; when
// housekeeping runs it first sorts in three passes over the list and then
// releases one worker a cycle. The list memory has a single read port.
// Reset clears the list, all worker marks, the clock and the request age, and
// loads the limit registers with 1, 16 and 60. The result cannot be stalled;
// busy stays high from acceptance until the cycle the result strobe rises.
module worker_pool_allocator_core #(
  parameter int unsigned HOUSEKEEP_PERIOD = 32,
  parameter int unsigned TIME_BITS        = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  wpa_pkg::req_t  req_i,
  output logic           done_o,
  output wpa_pkg::res_t  res_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [31:0]    cfg_wdata_i
);
  import wpa_pkg::*;

  // Command and status between the sequencer and the datapath.
  op_e        op;
  dp_status_t st;

  wpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .st_i   (st),
    .op_o   (op)
  );

  // The datapath latches the request itself on the accepting edge.
  wpa_dpath #(
    .HOUSEKEEP_PERIOD (HOUSEKEEP_PERIOD),
    .TIME_BITS        (TIME_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (op),
    .st_o        (st),
    .res_o       (res_o)
  );

endmodule

// ===== tb/sv/worker_pool_allocator_core_tb.sv =====
// Self-checking testbench for worker_pool_allocator_core: directed and random
// commands, with a per-request predictor of the worker list built in.
// Depends on wpa_pkg and the RTL of worker_pool_allocator_core.
`timescale 1ns / 100ps

module worker_pool_allocator_core_tb;
  import wpa_pkg::*;

  // Command codes that the block accepts but does not act on.
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam int unsigned AGE_PERIOD = 32;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RANDOM_PER_PHASE = 125;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  logic        done_o;
  res_t        res_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  worker_pool_allocator_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Requests waiting to be sent and results the pool model says must come.
  req_t pending_reqs[$];
  res_t expected_results[$];
  int unsigned sender_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Mirror of the pool: configuration and worker list.
  logic [4:0]  cfg_min = 5'd1;
  logic [4:0]  cfg_max = 5'd16;
  logic [31:0] cfg_limit = 32'd60;
  logic [3:0]  pool_order[NumWorkers];
  int unsigned pool_len = 0;
  logic [NumWorkers-1:0] pool_listed = '0;
  logic [NumWorkers-1:0] pool_busy = '0;
  logic [NumWorkers-1:0] pool_finished = '0;
  logic [31:0] pool_idle_since[NumWorkers];
  logic [31:0] pool_now = '0;
  int unsigned pool_req_age = 0;

  function automatic int unsigned eff_min();
    return (cfg_min > NumWorkers) ? NumWorkers : cfg_min;
  endfunction

  function automatic int unsigned eff_max();
    return (cfg_max > NumWorkers) ? NumWorkers : cfg_max;
  endfunction

  // Busy workers rank first, then idle ones still within the idle limit.
  // An idle worker that never finished a job counts as expired.
  function automatic logic [1:0] worker_class(input logic [3:0] id);
    if (pool_busy[id]) return CLS_BUSY;
    if (!pool_finished[id]) return CLS_EXPIRED;
    return ((pool_now - pool_idle_since[id]) < cfg_limit) ? CLS_FRESH : CLS_EXPIRED;
  endfunction

  function automatic void drop_worker(input logic [3:0] id);
    pool_listed[id] = 1'b0;
    pool_busy[id] = 1'b0;
    pool_finished[id] = 1'b0;
  endfunction

  // Stable sort into busy, fresh and expired, then release expired workers
  // from the back. Returns how many were released.
  function automatic int unsigned housekeep_pool();
    logic [3:0]  sorted[NumWorkers];
    int unsigned n;
    int unsigned keep;
    int unsigned released;
    n = 0;
    keep = 0;
    released = 0;
    pool_req_age = 0;
    if (pool_len <= eff_min()) return 0;
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < pool_len; i++) begin
        if (worker_class(pool_order[i]) == 2'(c)) begin
          sorted[n] = pool_order[i];
          n++;
          if (c < 2) keep++;
        end
      end
    end
    for (int i = 0; i < n; i++) pool_order[i] = sorted[i];
    if (keep < eff_min()) keep = eff_min();
    while (pool_len > keep) begin
      pool_len--;
      drop_worker(pool_order[pool_len]);
      released++;
    end
    return released;
  endfunction

  // Adds the lowest unlisted id at the end; returns NumWorkers if full.
  function automatic int unsigned append_worker(input logic make_busy);
    int unsigned id;
    id = 0;
    while (id < NumWorkers && pool_listed[id]) id++;
    if (id >= NumWorkers || pool_len >= NumWorkers) return NumWorkers;
    pool_listed[id] = 1'b1;
    pool_busy[id] = make_busy;
    pool_finished[id] = 1'b0;
    pool_order[pool_len] = 4'(id);
    pool_len++;
    return id;
  endfunction

  function automatic res_t predict_pool(input req_t r);
    res_t        o;
    int unsigned busy_n;
    int unsigned idle_n;
    int unsigned got;
    int          free_n;
    logic        found;
    o = '0;
    o.status = ST_OK;
    busy_n = 0;
    idle_n = 0;
    found = 1'b0;
    case (r.cmd)
      CMD_REQUEST: begin
        pool_req_age++;
        if (pool_req_age >= AGE_PERIOD) o.released_count = 5'(housekeep_pool());
        for (int i = 0; i < pool_len && !found; i++) begin
          if (!pool_busy[pool_order[i]]) begin
            pool_busy[pool_order[i]] = 1'b1;
            o.granted_id = pool_order[i];
            found = 1'b1;
          end
        end
        if (!found) begin
          if (pool_len < eff_max()) begin
            got = append_worker(1'b1);
            if (got < NumWorkers) o.granted_id = 4'(got);
            else o.status = ST_NO_AVAIL;
          end else begin
            o.status = ST_NO_AVAIL;
          end
        end
      end
      CMD_DONE: begin
        if (pool_listed[r.worker_id] && pool_busy[r.worker_id]) begin
          pool_busy[r.worker_id] = 1'b0;
          pool_finished[r.worker_id] = 1'b1;
          pool_idle_since[r.worker_id] = pool_now;
        end else begin
          o.status = ST_IGNORED;
        end
      end
      CMD_TICK: pool_now = pool_now + 32'd1;
      CMD_COLLECT: o.released_count = 5'(housekeep_pool());
      CMD_STOP_ALL: begin
        for (int i = 0; i < pool_len; i++) drop_worker(pool_order[i]);
        o.released_count = 5'(pool_len);
        pool_len = 0;
      end
      CMD_POPULATE: begin
        while (pool_len < eff_min()) begin
          if (append_worker(1'b0) >= NumWorkers) break;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < pool_len; i++) begin
      if (pool_busy[pool_order[i]]) busy_n++;
      else idle_n++;
    end
    free_n = int'(idle_n) + int'(eff_max()) - int'(pool_len);
    if (free_n < 0) free_n = 0;
    o.allocated_count = 5'(pool_len);
    o.busy_count = 5'(busy_n);
    o.free_count = 5'(free_n);
    return o;
  endfunction

  // Request driver: a request leaves at each edge where start is high and
  // busy low; the next one is offered at once unless the sender idles.
  always @(posedge clk_i) begin
    logic offer;
    offer = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        expected_results = {expected_results, predict_pool(req_i)};
        void'(pending_reqs.pop_front());
      end
      if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        offer = 1'b1;
        req_i <= pending_reqs[0];
      end
    end
    start <= offer;
  end

  // Result monitor: every strobe is matched against the oldest expectation.
  always @(posedge clk_i) begin
    res_t exp_res;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", res_o);
      end else begin
        exp_res = expected_results.pop_front();
        if (res_o !== exp_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p, got %p", exp_res, res_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("worker_pool_allocator_core_tb: done, errors");
      $finish;
    end
  end

  task automatic send(input logic [2:0] cmd, input logic [3:0] id);
    req_t r;
    r.cmd = cmd;
    r.worker_id = id;
    pending_reqs = {pending_reqs, r};
  endtask

  // Waits until every request is out and every result has come, then lets
  // the clock run on idle before anything else happens.
  task automatic drain();
    wait (pending_reqs.size() == 0 && expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MIN: cfg_min = val[4:0];
      REG_MAX: cfg_max = val[4:0];
      REG_LIMIT: cfg_limit = val;
      default: ;
    endcase
  endtask

  // Mostly requests and completions of plausible workers so the list fills,
  // drains, expires; the rest are ticks, sweeps, populates, stray commands.
  task automatic random_traffic(input int unsigned count);
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 36) send(CMD_REQUEST, 4'($urandom));
      else if (pick < 62) send(CMD_DONE, 4'($urandom_range(15)));
      else if (pick < 84) send(CMD_TICK, 4'($urandom));
      else if (pick < 90) send(CMD_COLLECT, 4'($urandom));
      else if (pick < 93) send(CMD_STOP_ALL, 4'($urandom));
      else if (pick < 98) send(CMD_POPULATE, 4'($urandom));
      else send(3'($urandom_range(7, 6)), 4'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset limits: first grant of a populated idle
    // worker, growth, done twice and for a worker never listed, a tick,
    // sweeps, the spare commands and stop-all.
    send(CMD_POPULATE, 4'd0);
    send(CMD_REQUEST, 4'd0);
    send(CMD_REQUEST, 4'd15);
    send(CMD_DONE, 4'd1);
    send(CMD_DONE, 4'd1);
    send(CMD_DONE, 4'd15);
    send(CMD_TICK, 4'd0);
    send(CMD_COLLECT, 4'd0);
    send(CMD_SPARE_A, 4'd5);
    send(CMD_SPARE_B, 4'd10);
    send(CMD_REQUEST, 4'd0);
    send(CMD_REQUEST, 4'd0);
    send(CMD_DONE, 4'd0);
    send(CMD_STOP_ALL, 4'd0);
    send(CMD_COLLECT, 4'd0);
    drain();

    // Short idle limit, large minimum: populate creates never-finished
    // workers that housekeeping must treat as expired.
    write_reg(REG_MIN, 32'd3);
    write_reg(REG_LIMIT, 32'd1);
    send(CMD_POPULATE, 4'd0);
    for (int i = 0; i < 5; i++) send(CMD_REQUEST, 4'd0);
    send(CMD_DONE, 4'd2);
    send(CMD_DONE, 4'd4);
    send(CMD_COLLECT, 4'd0);
    send(CMD_TICK, 4'd0);
    send(CMD_COLLECT, 4'd0);
    drain();

    write_reg(REG_MIN, 32'd1);
    write_reg(REG_MAX, 32'd16);
    write_reg(REG_LIMIT, 32'd3);
    sender_idle_pct = 38;
    random_traffic(RANDOM_PER_PHASE);
    drain();

    // Small maximum: the free count clamps at zero once the busy count reaches it.
    write_reg(REG_MIN, 32'd4);
    write_reg(REG_MAX, 32'd6);
    write_reg(REG_LIMIT, 32'd2);
    sender_idle_pct = 83;
    random_traffic(RANDOM_PER_PHASE);
    drain();

    // Out-of-range limits, maximum below minimum, and an idle limit nobody
    // reaches.
    write_reg(REG_MIN, 32'd31);
    write_reg(REG_MAX, 32'd2);
    write_reg(REG_LIMIT, 32'hFFFF_FFFF);
    sender_idle_pct = 0;
    random_traffic(RANDOM_PER_PHASE);
    drain();

    write_reg(REG_MIN, 32'd16);
    write_reg(REG_MAX, 32'd31);
    write_reg(REG_LIMIT, 32'd1);
    random_traffic(RANDOM_PER_PHASE);
    drain();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("worker_pool_allocator_core_tb: done, clean");
    end else begin
      $display("worker_pool_allocator_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/wpa_pkg.sv
hdl/wpa_ctrl.sv
hdl/wpa_dpath.sv
hdl/worker_pool_allocator_core.sv
tb/sv/worker_pool_allocator_core_tb.sv
